// ----- hw/rtl/jhd_pkg.sv -----
// ----------------------------------------------------------------------------
// jhd_pkg
// Types, codes and sizes shared by the JPEG Huffman block decoder modules.
// ----------------------------------------------------------------------------
package jhd_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_DEPTH    = 256;
    localparam int NUM_TABLES      = 4;
    localparam int NUM_QUANT       = 2;
    localparam int BLOCK_COEFS     = 64;
    localparam int COUNT_DEPTH     = NUM_TABLES * 16;
    localparam int SYM_DEPTH_ALL   = NUM_TABLES * 256;
    localparam int QUANT_DEPTH     = NUM_QUANT * BLOCK_COEFS;

    localparam logic [2:0] MODE_COUNT  = 3'd0;
    localparam logic [2:0] MODE_SYMBOL = 3'd1;
    localparam logic [2:0] MODE_QUANT  = 3'd2;
    localparam logic [2:0] MODE_BIT    = 3'd3;
    localparam logic [2:0] MODE_START  = 3'd4;

    localparam logic [1:0] PH_DC    = 2'd0;
    localparam logic [1:0] PH_AC    = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_HALT  = 2'd3;

    localparam logic [2:0] LAST_BLOCK  = 3'd5;
    localparam logic [2:0] FIRST_CB    = 3'd4;
    localparam logic [5:0] LAST_POS    = 6'd63;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] table_select;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic       stream_bit;
    } jhd_item_t;

    typedef struct packed {
        logic [2:0]         block_index;
        logic [5:0]         position;
        logic signed [23:0] coefficient;
        logic               coef_valid;
        logic               block_end;
        logic               error;
    } jhd_result_t;

endpackage

// ----- hw/rtl/jhd_ram.sv -----
// ----------------------------------------------------------------------------
// jhd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module jhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/jhd_engine.sv -----
// ----------------------------------------------------------------------------
// jhd_engine
// Table memories and the bit-serial decode sequencer around them.
// ----------------------------------------------------------------------------
module jhd_engine import jhd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  jhd_item_t   item,
    output logic        item_take,
    output logic        res_valid,
    input  logic        res_ready,
    output jhd_result_t res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COUNT = 5'b00010,
        ST_SYM   = 5'b00100,
        ST_QUANT = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  blk_reg, blk_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] accum_reg, accum_next;
    logic [4:0]  len_reg, len_next;
    logic [16:0] first_reg, first_next;
    logic [7:0]  offset_reg, offset_next;
    logic [15:0] vacc_reg, vacc_next;
    logic [3:0]  vleft_reg, vleft_next;
    logic [7:0]  psym_reg, psym_next;
    logic [1:0]  tbl_reg, tbl_next;
    logic        oob_reg, oob_next;
    logic [15:0] pred_reg [3];
    logic [15:0] pred_next [3];
    logic signed [15:0] val_reg, val_next;
    logic signed [15:0] base_reg, base_next;
    logic [7:0]  q_reg, q_next;
    jhd_result_t r_reg, r_next;
    logic        coef_en_reg, coef_en_next;

    logic       cnt_we, sym_we, q_we;
    logic [5:0] cnt_waddr, cnt_raddr;
    logic [9:0] sym_waddr, sym_raddr;
    logic [6:0] q_waddr, q_raddr;
    logic [7:0] cnt_rd, sym_rd, q_rd;

    logic        chroma;
    logic [16:0] diff;
    logic        match;
    logic [7:0]  sidx;
    logic [7:0]  sym;
    logic [6:0]  target;
    logic [1:0]  pidx;
    logic [15:0] nv;
    logic [15:0] shifted;
    logic [16:0] first_sum;
    logic signed [24:0] product;

    jhd_ram #(.WIDTH(8), .DEPTH(COUNT_DEPTH)) u_counts (
        .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(item.entry_value),
        .rd_addr(cnt_raddr), .rd_data(cnt_rd)
    );
    jhd_ram #(.WIDTH(8), .DEPTH(SYM_DEPTH_ALL)) u_symbols (
        .clk(clk), .wr_en(sym_we), .wr_addr(sym_waddr), .wr_data(item.entry_value),
        .rd_addr(sym_raddr), .rd_data(sym_rd)
    );
    jhd_ram #(.WIDTH(8), .DEPTH(QUANT_DEPTH)) u_quant (
        .clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(item.entry_value),
        .rd_addr(q_raddr), .rd_data(q_rd)
    );

    // Sign-extend size bits of a gathered value.
    function automatic logic signed [15:0] extend(input logic [15:0] raw,
                                                   input logic [3:0] size);
        logic [15:0] half;
        logic [15:0] full;
        begin
            half = 16'd1 << (size - 4'd1);
            full = 16'd1 << size;
            if (size == 4'd0)
                extend = 16'sd0;
            else if (raw >= half)
                extend = signed'(raw);
            else
                extend = signed'(raw - full + 16'd1);
        end
    endfunction

    assign chroma  = (blk_reg >= FIRST_CB);
    assign diff    = {1'b0, accum_reg} - first_reg;
    assign match   = ({1'b0, accum_reg} >= first_reg) && (diff < {9'd0, cnt_rd});
    assign sidx    = offset_reg + diff[7:0];
    assign sym     = oob_reg ? 8'd0 : sym_rd;
    assign target  = {1'b0, pos_reg} + 7'd1 + {3'd0, sym[7:4]};
    assign pidx    = (blk_reg < FIRST_CB) ? 2'd0 : ((blk_reg == FIRST_CB) ? 2'd1 : 2'd2);
    assign nv      = pred_reg[pidx] + val_reg;
    assign shifted = {vacc_reg[14:0], item.stream_bit};
    assign first_sum = first_reg + {9'd0, cnt_rd};
    assign product = base_reg * signed'({1'b0, q_reg});

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        blk_next     = blk_reg;
        pos_next     = pos_reg;
        accum_next   = accum_reg;
        len_next     = len_reg;
        first_next   = first_reg;
        offset_next  = offset_reg;
        vacc_next    = vacc_reg;
        vleft_next   = vleft_reg;
        psym_next    = psym_reg;
        tbl_next     = tbl_reg;
        oob_next     = oob_reg;
        pred_next    = pred_reg;
        val_next     = val_reg;
        base_next    = base_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        coef_en_next = coef_en_reg;
        item_take    = 1'b0;
        res_valid    = 1'b0;
        cnt_we       = 1'b0;
        sym_we       = 1'b0;
        q_we         = 1'b0;
        cnt_waddr    = {item.table_select, item.entry_index[3:0]};
        sym_waddr    = {item.table_select, item.entry_index};
        q_waddr      = {item.table_select[0], item.entry_index[5:0]};
        cnt_raddr    = {tbl_reg, len_reg[3:0]};
        sym_raddr    = {tbl_reg, sidx};
        q_raddr      = {chroma, pos_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_take = 1'b1;
                    case (item.mode)
                        MODE_COUNT:
                            cnt_we = ({1'b0, item.entry_index} < 9'(MAX_CODE_LENGTH));
                        MODE_SYMBOL:
                            sym_we = ({1'b0, item.entry_index} < 9'(SYMBOL_DEPTH));
                        MODE_QUANT:
                            q_we = (item.table_select < 2'(NUM_QUANT))
                                && (item.entry_index < 8'(BLOCK_COEFS));
                        MODE_START:
                        begin
                            pred_next  = '{16'd0, 16'd0, 16'd0};
                            blk_next   = 3'd0;
                            pos_next   = 6'd0;
                            phase_next = PH_DC;
                            accum_next = 16'd0;
                            len_next   = 5'd0;
                            first_next = 17'd0;
                            offset_next = 8'd0;
                            vacc_next  = 16'd0;
                            vleft_next = 4'd0;
                            psym_next  = 8'd0;
                        end
                        MODE_BIT:
                        begin
                            if (phase_reg == PH_VALUE)
                            begin
                                vacc_next  = shifted;
                                vleft_next = vleft_reg - 4'd1;
                                if (vleft_reg == 4'd1)
                                begin
                                    val_next   = extend(shifted, psym_reg[3:0]);
                                    state_next = ST_QUANT;
                                end
                            end
                            else if (phase_reg != PH_HALT)
                            begin
                                tbl_next   = {phase_reg == PH_AC, chroma};
                                accum_next = {accum_reg[14:0], item.stream_bit};
                                len_next   = len_reg + 5'd1;
                                cnt_raddr  = {phase_reg == PH_AC, chroma, len_reg[3:0]};
                                state_next = ST_COUNT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                if (match)
                begin
                    oob_next   = ({1'b0, sidx} >= 9'(SYMBOL_DEPTH));
                    state_next = ST_SYM;
                end
                else if (len_reg >= 5'(MAX_CODE_LENGTH))
                begin
                    r_next       = '{blk_reg, 6'd0, 24'sd0, 1'b0, 1'b0, 1'b1};
                    coef_en_next = 1'b0;
                    phase_next   = PH_HALT;
                    accum_next   = 16'd0;
                    len_next     = 5'd0;
                    first_next   = 17'd0;
                    offset_next  = 8'd0;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    offset_next = offset_reg + cnt_rd;
                    first_next  = {first_sum[15:0], 1'b0};
                    state_next  = ST_IDLE;
                end
            end
            ST_SYM:
            begin
                accum_next  = 16'd0;
                len_next    = 5'd0;
                first_next  = 17'd0;
                offset_next = 8'd0;
                coef_en_next = 1'b0;
                if (phase_reg == PH_AC && sym == 8'd0)
                begin
                    // End of block: flag only, no coefficient.
                    r_next     = '{blk_reg, 6'd0, 24'sd0, 1'b0, 1'b1, 1'b0};
                    blk_next   = (blk_reg >= LAST_BLOCK) ? 3'd0 : blk_reg + 3'd1;
                    pos_next   = 6'd0;
                    phase_next = PH_DC;
                    state_next = ST_EMIT;
                end
                else if (phase_reg == PH_AC && target > {1'b0, LAST_POS})
                begin
                    r_next     = '{blk_reg, 6'd0, 24'sd0, 1'b0, 1'b0, 1'b1};
                    phase_next = PH_HALT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (phase_reg == PH_AC)
                    begin
                        pos_next = target[5:0];
                        q_raddr  = {chroma, target[5:0]};
                    end
                    if (sym[3:0] == 4'd0)
                    begin
                        val_next   = 16'sd0;
                        state_next = ST_QUANT;
                    end
                    else
                    begin
                        psym_next  = sym;
                        vacc_next  = 16'd0;
                        vleft_next = sym[3:0];
                        phase_next = PH_VALUE;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_QUANT:
            begin
                q_next       = q_rd;
                coef_en_next = 1'b1;
                if (pos_reg == 6'd0)
                begin
                    pred_next[pidx] = nv;
                    base_next       = signed'(nv);
                end
                else
                begin
                    base_next = val_reg;
                end
                r_next = '{blk_reg, pos_reg, 24'sd0, 1'b1, pos_reg == LAST_POS, 1'b0};
                if (pos_reg == LAST_POS)
                begin
                    blk_next   = (blk_reg >= LAST_BLOCK) ? 3'd0 : blk_reg + 3'd1;
                    pos_next   = 6'd0;
                    phase_next = PH_DC;
                end
                else
                begin
                    phase_next = PH_AC;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res = r_reg;
        res.coefficient = coef_en_reg ? product[23:0] : 24'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_DC;
            blk_reg    <= 3'd0;
            pos_reg    <= 6'd0;
            accum_reg  <= 16'd0;
            len_reg    <= 5'd0;
            first_reg  <= 17'd0;
            offset_reg <= 8'd0;
            vacc_reg   <= 16'd0;
            vleft_reg  <= 4'd0;
            psym_reg   <= 8'd0;
            pred_reg   <= '{16'd0, 16'd0, 16'd0};
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            blk_reg    <= blk_next;
            pos_reg    <= pos_next;
            accum_reg  <= accum_next;
            len_reg    <= len_next;
            first_reg  <= first_next;
            offset_reg <= offset_next;
            vacc_reg   <= vacc_next;
            vleft_reg  <= vleft_next;
            psym_reg   <= psym_next;
            pred_reg   <= pred_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg     <= tbl_next;
        oob_reg     <= oob_next;
        val_reg     <= val_next;
        base_reg    <= base_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        coef_en_reg <= coef_en_next;
    end

endmodule

// ----- hw/rtl/jpeg_huffman_block_decoder.sv -----
// ----------------------------------------------------------------------------
// jpeg_huffman_block_decoder
// Bit-serial baseline JPEG entropy decoder for 4:2:0 MCUs.
// ----------------------------------------------------------------------------
// Load Huffman code counts, symbols and quantizers with beats of modes 0..2,
// send a start-scan beat, then feed the entropy-coded stream one bit per beat.
// Each MCU is four luma blocks, then Cb and Cr; chroma uses DC table 1, AC
// table 3 and quant table 1. Results are dequantized coefficients in zigzag
// order, an end-of-block marker, or an error beat after which the decoder
// ignores bits until the next start scan. Tables live in three synchronous
// RAMs with registered read ports. A code bit that does not finish a code
// passes a count RAM read, then a compare; a bit that finishes a code adds
// the symbol RAM read, and a coefficient adds the quant RAM read and an
// output state. The last value bit goes on to the quant RAM read; other
// value bits, loads and start scan are handled in the idle state alone. A
// one-beat input buffer takes the next beat while the current one is
// decoded, and the output register holds a result until it is taken.
module jpeg_huffman_block_decoder import jhd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  jhd_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output jhd_result_t result
);

    jhd_item_t   buf_reg;
    logic        buf_valid_reg, buf_valid_next;
    jhd_result_t out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        eng_take;
    logic        eng_res_valid;
    logic        eng_res_ready;
    jhd_result_t eng_res;

    // Input buffer: take a beat when empty or when the held beat leaves.
    assign item_ready = !buf_valid_reg || eng_take;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (eng_take)
            buf_valid_next = 1'b0;
        if (item_valid && item_ready)
            buf_valid_next = 1'b1;
    end

    jhd_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(buf_valid_reg),
        .item(buf_reg),
        .item_take(eng_take),
        .res_valid(eng_res_valid),
        .res_ready(eng_res_ready),
        .res(eng_res)
    );

    // Output register: advance when empty or when the held beat is taken.
    assign eng_res_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (eng_res_valid && eng_res_ready)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            buf_reg <= item;
        if (eng_res_valid && eng_res_ready)
            out_reg <= eng_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // An error beat carries no coefficient and no block end.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error |-> !result.coef_valid && !result.block_end)
        else $error("error beat carries coefficient or block end");

    // A beat without coefficient and without error is an end-of-block marker.
    a_eob_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.coef_valid && !result.error |-> result.block_end)
        else $error("empty beat without block end");

    a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.block_index <= LAST_BLOCK)
        else $error("block index out of range");

    // A buffered beat stays until the engine takes it.
    a_buf_hold: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg && !eng_take |=> buf_valid_reg && $stable(buf_reg))
        else $error("buffered beat lost");

endmodule
